FILE: src/hctb_pkg.sv
// Shared types and constants of the Huffman code table builder.
// No dependencies; every other file of the block but hctb_ram imports this package.
package hctb_pkg;

    localparam int OPCODE_W    = 2;
    localparam int SYMBOL_W    = 8;
    localparam int TOTAL_W     = 32;
    localparam int LEN_W       = 7;
    localparam int CODE_BITS_W = 64;
    localparam int WEIGHT_W    = 40;
    localparam int STORE_LEN_W = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_COUNT = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic {
        KIND_BUILD = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    // One classified command between the front queue and the executor
    typedef struct packed {
        op_t                 op;
        logic [SYMBOL_W-1:0] symbol;
        logic                in_range;
    } cmd_t;

endpackage

FILE: src/hctb_in_if.sv
// Request channel of the Huffman code table builder: opcode and symbol.
// Depends on hctb_pkg.
interface hctb_in_if;
    import hctb_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [SYMBOL_W-1:0] symbol;

    modport source (output valid, output opcode, output symbol, input ready);
    modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

FILE: src/hctb_out_if.sv
// Result channel of the Huffman code table builder: build reports and code answers.
// Depends on hctb_pkg.
interface hctb_out_if;
    import hctb_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [TOTAL_W-1:0]     total_count;
    logic [LEN_W-1:0]       code_length;
    logic [CODE_BITS_W-1:0] code_bits;
    logic                   too_long;

    modport source (output valid, output kind, output total_count, output code_length,
                    output code_bits, output too_long, input ready);
    modport sink   (input valid, input kind, input total_count, input code_length,
                    input code_bits, input too_long, output ready);
endinterface

FILE: src/hctb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/hctb_front.sv
// Front part: accepts requests, classifies them and queues them for the executor.
// Depends on hctb_pkg and hctb_in_if.
module hctb_front #(
    parameter int SYMBOLS = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    hctb_in_if.sink       request,
    output logic          cmd_valid,
    output hctb_pkg::cmd_t cmd,
    input  logic          cmd_take
);
    import hctb_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    cmd_t       q_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    cmd_t       incoming;

    // Classify the incoming transaction
    always_comb
    begin
        incoming.op       = op_t'(request.opcode);
        incoming.symbol   = request.symbol;
        incoming.in_range = ({1'b0, request.symbol} < 9'(SYMBOLS));
    end

    assign request.ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push          = request.valid && request.ready;
    assign cmd_valid     = (cnt_reg != 2'd0);
    assign cmd           = q_reg[rd_ptr_reg];

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= incoming;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !cmd_take)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (!push && cmd_take)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end
endmodule

FILE: src/hctb_back.sv
// Back part: histogram, tree merges, code walk and queries, plus the result register.
// Depends on hctb_pkg, hctb_out_if and hctb_ram.
module hctb_back #(
    parameter int SYMBOLS      = 256,
    parameter int COUNT_WIDTH  = 32,
    parameter int MAX_CODE_LEN = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  hctb_pkg::cmd_t cmd,
    output logic           cmd_take,
    hctb_out_if.source     result
);
    import hctb_pkg::*;

    localparam int NODES   = 2 * SYMBOLS - 1;
    localparam int NODE_W  = $clog2(NODES);
    localparam int SYM_W   = $clog2(SYMBOLS);
    localparam int LEFT_N  = SYMBOLS - 1;
    localparam int LEFT_AW = (LEFT_N > 1) ? $clog2(LEFT_N) : 1;
    localparam int PAR_W   = NODE_W + 1;
    localparam int CODE_W  = CODE_BITS_W + STORE_LEN_W;

    localparam logic [WEIGHT_W-1:0] COUNT_MAX =
        WEIGHT_W'((41'd1 << COUNT_WIDTH) - 41'd1);
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = {TOTAL_W{1'b1}};
    localparam logic [NODE_W-1:0]   SYM_BASE   = NODE_W'(SYMBOLS);
    localparam logic [NODE_W-1:0]   LAST_NODE  = NODE_W'(NODES - 1);
    localparam logic [SYM_W-1:0]    LAST_SYM   = SYM_W'(SYMBOLS - 1);
    localparam logic [LEFT_AW-1:0]  LAST_MERGE = LEFT_AW'(SYMBOLS - 2);
    localparam logic [LEN_W-1:0]    MAX_LEN    = LEN_W'(MAX_CODE_LEN);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CNT_WR, ST_Q_RD, ST_PCLR, ST_SCAN, ST_SCAN_END, ST_MRG1, ST_MRG2,
        ST_LW_P, ST_LW_D, ST_CW_P, ST_CW_L, ST_CW_B, ST_CODE_WR, ST_RESP
    } state_t;

    state_t                  state_reg;
    logic [SYMBOLS-1:0]      hvalid_reg;
    logic [TOTAL_W-1:0]      total_reg;
    logic [SYM_W-1:0]        sym_reg;
    logic [NODE_W-1:0]       j_reg;
    logic [LEFT_AW-1:0]      i_reg;
    logic                    sv_reg;
    logic [NODE_W-1:0]       sj_reg;
    logic                    b1_ok_reg;
    logic                    b2_ok_reg;
    logic [NODE_W-1:0]       b1_reg;
    logic [NODE_W-1:0]       b2_reg;
    logic [WEIGHT_W-1:0]     w1_reg;
    logic [WEIGHT_W-1:0]     w2_reg;
    logic [SYM_W-1:0]        s_reg;
    logic [NODE_W-1:0]       c_reg;
    logic [NODE_W-1:0]       p_reg;
    logic [STORE_LEN_W-1:0]  len_reg;
    logic [STORE_LEN_W-1:0]  d_reg;
    logic [CODE_BITS_W-1:0]  code_reg;
    kind_t                   res_kind_reg;
    logic [LEN_W-1:0]        res_len_reg;
    logic [CODE_BITS_W-1:0]  res_code_reg;
    logic                    res_long_reg;
    logic                    out_valid_reg;
    logic                    out_kind_reg;
    logic [TOTAL_W-1:0]      out_total_reg;
    logic [LEN_W-1:0]        out_len_reg;
    logic [CODE_BITS_W-1:0]  out_code_reg;
    logic                    out_long_reg;

    // RAM ports
    logic                wt_we;
    logic [NODE_W-1:0]   wt_waddr;
    logic [WEIGHT_W-1:0] wt_wdata;
    logic [NODE_W-1:0]   wt_raddr;
    logic [WEIGHT_W-1:0] wt_rdata;
    logic                par_we;
    logic [NODE_W-1:0]   par_waddr;
    logic [PAR_W-1:0]    par_wdata;
    logic [NODE_W-1:0]   par_raddr;
    logic [PAR_W-1:0]    par_rdata;
    logic                lft_we;
    logic [LEFT_AW-1:0]  lft_waddr;
    logic [NODE_W-1:0]   lft_wdata;
    logic [LEFT_AW-1:0]  lft_raddr;
    logic [NODE_W-1:0]   lft_rdata;
    logic                cs_we;
    logic [SYM_W-1:0]    cs_waddr;
    logic [CODE_W-1:0]   cs_wdata;
    logic [SYM_W-1:0]    cs_raddr;
    logic [CODE_W-1:0]   cs_rdata;

    // Datapath helpers
    logic [NODE_W-1:0]      limit;
    logic [NODE_W-1:0]      p_off;
    logic [WEIGHT_W:0]      wsum;
    logic [WEIGHT_W-1:0]    merged_w;
    logic [WEIGHT_W-1:0]    old_cnt;
    logic [WEIGHT_W-1:0]    scan_w;
    logic [LEN_W-1:0]       kept;
    logic [STORE_LEN_W-1:0] bit_pos;
    logic [STORE_LEN_W-1:0] q_len;
    logic                   q_long;
    logic                   out_free;

    hctb_ram #(.WIDTH(WEIGHT_W), .DEPTH(NODES)) u_weight (
        .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
        .raddr(wt_raddr), .rdata(wt_rdata)
    );
    hctb_ram #(.WIDTH(PAR_W), .DEPTH(NODES)) u_parent (
        .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata)
    );
    hctb_ram #(.WIDTH(NODE_W), .DEPTH(LEFT_N)) u_left (
        .clk(clk), .we(lft_we), .waddr(lft_waddr), .wdata(lft_wdata),
        .raddr(lft_raddr), .rdata(lft_rdata)
    );
    hctb_ram #(.WIDTH(CODE_W), .DEPTH(SYMBOLS)) u_code (
        .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
        .raddr(cs_raddr), .rdata(cs_rdata)
    );

    // Merge arithmetic, old count, scan weight, length clipping, query decode and output free
    always_comb
    begin
        limit    = SYM_BASE + NODE_W'(i_reg);
        p_off    = par_rdata[NODE_W-1:0] - SYM_BASE;
        wsum     = {1'b0, w1_reg} + {1'b0, w2_reg};
        merged_w = wsum[WEIGHT_W] ? WEIGHT_MAX : wsum[WEIGHT_W-1:0];
        old_cnt  = hvalid_reg[sym_reg] ? wt_rdata : '0;
        if ((sj_reg < SYM_BASE) && !hvalid_reg[sj_reg[SYM_W-1:0]])
        begin
            scan_w = '0;
        end
        else
        begin
            scan_w = wt_rdata;
        end
        kept     = (len_reg > STORE_LEN_W'(MAX_CODE_LEN)) ? MAX_LEN : len_reg[LEN_W-1:0];
        bit_pos  = STORE_LEN_W'(kept) - STORE_LEN_W'(1) - d_reg;
        q_len    = cs_rdata[CODE_W-1:CODE_BITS_W];
        q_long   = (q_len > STORE_LEN_W'(MAX_CODE_LEN));
        out_free = !out_valid_reg || result.ready;
    end

    assign cmd_take = (state_reg == ST_IDLE) && cmd_valid;

    // Drive RAM ports from the current step
    always_comb
    begin
        wt_we     = 1'b0;
        wt_waddr  = NODE_W'(sym_reg);
        wt_wdata  = old_cnt + WEIGHT_W'(1);
        wt_raddr  = (state_reg == ST_IDLE) ? NODE_W'(cmd.symbol[SYM_W-1:0]) : j_reg;
        par_we    = 1'b0;
        par_waddr = j_reg;
        par_wdata = {1'b1, {NODE_W{1'b0}}};
        par_raddr = (state_reg == ST_SCAN) ? j_reg : c_reg;
        lft_we    = 1'b0;
        lft_waddr = i_reg;
        lft_wdata = b1_reg;
        lft_raddr = p_off[LEFT_AW-1:0];
        cs_we     = 1'b0;
        cs_waddr  = s_reg;
        cs_wdata  = {len_reg, code_reg};
        cs_raddr  = cmd.symbol[SYM_W-1:0];
        case (state_reg)
            ST_CNT_WR:
            begin
                wt_we = (old_cnt < COUNT_MAX);
            end
            ST_PCLR:
            begin
                par_we = 1'b1;
            end
            ST_MRG1:
            begin
                wt_we     = 1'b1;
                wt_waddr  = limit;
                wt_wdata  = merged_w;
                par_we    = 1'b1;
                par_waddr = b1_reg;
                par_wdata = {1'b0, limit};
                lft_we    = 1'b1;
            end
            ST_MRG2:
            begin
                par_we    = 1'b1;
                par_waddr = b2_reg;
                par_wdata = {1'b0, limit};
            end
            ST_CODE_WR:
            begin
                cs_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer, histogram flags, scan tracking and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hvalid_reg    <= '0;
            total_reg     <= '0;
            sv_reg        <= 1'b0;
            b1_ok_reg     <= 1'b0;
            b2_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the result once taken; a result about to load is set below
            if (result.ready && (state_reg != ST_RESP))
            begin
                out_valid_reg <= 1'b0;
            end

            // Track the two lightest parentless nodes during a scan
            if (sv_reg && par_rdata[NODE_W])
            begin
                if (!b1_ok_reg || (scan_w < w1_reg))
                begin
                    b2_reg    <= b1_reg;
                    w2_reg    <= w1_reg;
                    b2_ok_reg <= b1_ok_reg;
                    b1_reg    <= sj_reg;
                    w1_reg    <= scan_w;
                    b1_ok_reg <= 1'b1;
                end
                else if (!b2_ok_reg || (scan_w < w2_reg))
                begin
                    b2_reg    <= sj_reg;
                    w2_reg    <= scan_w;
                    b2_ok_reg <= 1'b1;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        sym_reg <= cmd.symbol[SYM_W-1:0];
                        case (cmd.op)
                            OP_COUNT:
                            begin
                                if (cmd.in_range)
                                begin
                                    state_reg <= ST_CNT_WR;
                                end
                            end
                            OP_CLEAR:
                            begin
                                hvalid_reg <= '0;
                                total_reg  <= '0;
                            end
                            OP_BUILD:
                            begin
                                j_reg     <= '0;
                                state_reg <= ST_PCLR;
                            end
                            OP_QUERY:
                            begin
                                if (cmd.in_range)
                                begin
                                    state_reg <= ST_Q_RD;
                                end
                                else
                                begin
                                    res_kind_reg <= KIND_QUERY;
                                    res_len_reg  <= '0;
                                    res_code_reg <= '0;
                                    res_long_reg <= 1'b0;
                                    state_reg    <= ST_RESP;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_CNT_WR:
                begin
                    hvalid_reg[sym_reg] <= 1'b1;
                    if (total_reg != TOTAL_MAX)
                    begin
                        total_reg <= total_reg + TOTAL_W'(1);
                    end
                    state_reg <= ST_IDLE;
                end
                ST_Q_RD:
                begin
                    res_kind_reg <= KIND_QUERY;
                    res_len_reg  <= q_long ? MAX_LEN : q_len[LEN_W-1:0];
                    res_code_reg <= cs_rdata[CODE_BITS_W-1:0];
                    res_long_reg <= q_long;
                    state_reg    <= ST_RESP;
                end
                ST_PCLR:
                begin
                    if (j_reg == LAST_NODE)
                    begin
                        j_reg     <= '0;
                        i_reg     <= '0;
                        b1_ok_reg <= 1'b0;
                        b2_ok_reg <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        j_reg <= j_reg + NODE_W'(1);
                    end
                end
                ST_SCAN:
                begin
                    sv_reg <= 1'b1;
                    sj_reg <= j_reg;
                    if (j_reg == limit - NODE_W'(1))
                    begin
                        j_reg     <= '0;
                        state_reg <= ST_SCAN_END;
                    end
                    else
                    begin
                        j_reg <= j_reg + NODE_W'(1);
                    end
                end
                ST_SCAN_END:
                begin
                    sv_reg    <= 1'b0;
                    state_reg <= ST_MRG1;
                end
                ST_MRG1:
                begin
                    state_reg <= ST_MRG2;
                end
                ST_MRG2:
                begin
                    b1_ok_reg <= 1'b0;
                    b2_ok_reg <= 1'b0;
                    if (i_reg == LAST_MERGE)
                    begin
                        s_reg     <= '0;
                        c_reg     <= '0;
                        len_reg   <= '0;
                        state_reg <= ST_LW_P;
                    end
                    else
                    begin
                        i_reg     <= i_reg + LEFT_AW'(1);
                        state_reg <= ST_SCAN;
                    end
                end
                // Walk up once to measure the code length
                ST_LW_P:
                begin
                    state_reg <= ST_LW_D;
                end
                ST_LW_D:
                begin
                    if (par_rdata[NODE_W])
                    begin
                        d_reg    <= len_reg - STORE_LEN_W'(1);
                        c_reg    <= NODE_W'(s_reg);
                        code_reg <= '0;
                        if (len_reg == '0)
                        begin
                            state_reg <= ST_CODE_WR;
                        end
                        else
                        begin
                            state_reg <= ST_CW_P;
                        end
                    end
                    else
                    begin
                        c_reg     <= par_rdata[NODE_W-1:0];
                        len_reg   <= len_reg + STORE_LEN_W'(1);
                        state_reg <= ST_LW_P;
                    end
                end
                // Walk up again and place each branch bit
                ST_CW_P:
                begin
                    state_reg <= ST_CW_L;
                end
                ST_CW_L:
                begin
                    p_reg     <= par_rdata[NODE_W-1:0];
                    state_reg <= ST_CW_B;
                end
                ST_CW_B:
                begin
                    if (d_reg < STORE_LEN_W'(kept))
                    begin
                        code_reg[bit_pos[$clog2(CODE_BITS_W)-1:0]] <= (lft_rdata != c_reg);
                    end
                    c_reg <= p_reg;
                    if (d_reg == '0)
                    begin
                        state_reg <= ST_CODE_WR;
                    end
                    else
                    begin
                        d_reg     <= d_reg - STORE_LEN_W'(1);
                        state_reg <= ST_CW_P;
                    end
                end
                ST_CODE_WR:
                begin
                    if (s_reg == LAST_SYM)
                    begin
                        res_kind_reg <= KIND_BUILD;
                        res_len_reg  <= '0;
                        res_code_reg <= '0;
                        res_long_reg <= 1'b0;
                        state_reg    <= ST_RESP;
                    end
                    else
                    begin
                        s_reg     <= s_reg + SYM_W'(1);
                        c_reg     <= NODE_W'(s_reg + SYM_W'(1));
                        len_reg   <= '0;
                        state_reg <= ST_LW_P;
                    end
                end
                ST_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= res_kind_reg;
                        out_total_reg <= total_reg;
                        out_len_reg   <= res_len_reg;
                        out_code_reg  <= res_code_reg;
                        out_long_reg  <= res_long_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = out_kind_reg;
    assign result.total_count = out_total_reg;
    assign result.code_length = out_len_reg;
    assign result.code_bits   = out_code_reg;
    assign result.too_long    = out_long_reg;
endmodule

FILE: src/huffman_code_table_builder.sv
// Top level of the Huffman code table builder: front queue plus executor.
// Depends on hctb_pkg, hctb_in_if, hctb_out_if, hctb_front and hctb_back.
//
//  Channel  | Dir | Payload                                              | Transaction
//  ---------+-----+------------------------------------------------------+------------------
//  request  | in  | opcode, symbol                                       | valid && ready
//  result   | out | kind, total_count, code_length, code_bits, too_long  | valid && ready
//
// In the executor a count adds a count-write step, a clear is done in the idle state and a
// query reads the code RAM before it answers. A build clears the 2N-1 parent RAM entries,
// then for merge i scans N+i nodes through the weight/parent RAM read port, then walks each
// symbol to the root twice via the parent RAM (LW_P/LW_D per level, then CW_P/CW_L/CW_B).
// Reset clears only control state, histogram valid flags and total; no clearing pass.
// A two-entry queue decouples request intake from the executor; the result register
// lets the executor finish while the last result waits to be taken.
module huffman_code_table_builder #(
    parameter int SYMBOLS      = 256,
    parameter int COUNT_WIDTH  = 32,
    parameter int MAX_CODE_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    hctb_in_if.sink    request,
    hctb_out_if.source result
);
    import hctb_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    hctb_front #(.SYMBOLS(SYMBOLS)) u_front (
        .clk(clk), .rst_n(rst_n), .request(request),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
    );

    hctb_back #(
        .SYMBOLS(SYMBOLS), .COUNT_WIDTH(COUNT_WIDTH), .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take), .result(result)
    );

    // A full queue always has a command waiting for the executor
    a_full_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !request.ready |-> cmd_valid)
        else $error("queue full but no command pending");

    // An overlong code is reported at the clipped length
    a_long_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.too_long) |-> (result.code_length == LEN_W'(MAX_CODE_LEN)))
        else $error("too_long without clipped length");

    // Build reports carry no code
    a_build_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.kind == KIND_BUILD)) |->
        ((result.code_length == '0) && (result.code_bits == '0) && !result.too_long))
        else $error("build report with code fields set");
endmodule

FILE: verif/tb.sv
// Testbench for huffman_code_table_builder: directed, random and backpressure tests.
// Depends on hctb_pkg, hctb_in_if, hctb_out_if and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hctb_pkg::*;

    localparam int NSYM       = 256;
    localparam int NNODE      = 2 * NSYM - 1;
    localparam int NONE       = 1023;
    localparam int MAXLEN     = 64;
    localparam int CYCLE_CAP  = 4000000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_SAT = {WEIGHT_W{1'b1}};
    localparam logic [31:0]         COUNT_SAT  = 32'hFFFF_FFFF;

    typedef struct {
        kind_t                  kind;
        logic [TOTAL_W-1:0]     total;
        logic [LEN_W-1:0]       len;
        logic [CODE_BITS_W-1:0] code;
        logic                   too_long;
    } answer_t;

    logic clk;
    logic rst_n;

    hctb_in_if  req_if ();
    hctb_out_if res_if ();

    huffman_code_table_builder u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if),
        .result  (res_if)
    );

    // Shadow copy of the block's tree and code table
    logic [WEIGHT_W-1:0]    weight [NNODE];
    int                     parent [NNODE];
    int                     left_of [NSYM-1];
    logic [CODE_BITS_W-1:0] code_tab [NSYM];
    int                     len_tab [NSYM];
    logic [TOTAL_W-1:0]     sym_total;

    answer_t pending_answers [$];
    int      n_errors;
    int      burst_left;
    bit      gaps_on;
    bit      hold_off;
    int      stall_pct;
    longint  cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    function automatic int least_free(int limit, int skip);
        int best;
        best = -1;
        for (int j = 0; j < limit; j++)
        begin
            if (parent[j] != NONE || j == skip)
                continue;
            if (best < 0 || weight[j] < weight[best])
                best = j;
        end
        return best;
    endfunction

    // Merge the tree and derive every symbol's code
    function automatic void build_table();
        int                     x, y, c, p, depth, kept;
        logic [WEIGHT_W:0]      sum;
        logic [CODE_BITS_W-1:0] bits;
        for (int i = 0; i < NNODE; i++)
            parent[i] = NONE;
        for (int i = 0; i < NSYM - 1; i++)
        begin
            x = least_free(i + NSYM, -1);
            y = least_free(i + NSYM, x);
            parent[x] = i + NSYM;
            parent[y] = i + NSYM;
            left_of[i] = x;
            sum = {1'b0, weight[x]} + {1'b0, weight[y]};
            weight[i + NSYM] = (sum > WEIGHT_SAT) ? WEIGHT_SAT : sum[WEIGHT_W-1:0];
        end
        for (int s = 0; s < NSYM; s++)
        begin
            depth = 0;
            c = s;
            while (parent[c] != NONE && depth < NNODE)
            begin
                c = parent[c];
                depth++;
            end
            kept = (depth > MAXLEN) ? MAXLEN : depth;
            bits = '0;
            c = s;
            for (int d = depth - 1; d >= 0; d--)
            begin
                p = parent[c];
                if (d < kept && left_of[p - NSYM] != c)
                    bits[kept - 1 - d] = 1'b1;
                c = p;
            end
            code_tab[s] = bits;
            len_tab[s] = depth;
        end
    endfunction

    // Update the shadow state for one accepted transaction, queue any answer
    function automatic void apply_cmd(op_t op, logic [SYMBOL_W-1:0] s);
        answer_t a;
        a = '{KIND_BUILD, '0, '0, '0, 1'b0};
        case (op)
            OP_COUNT:
            begin
                if (weight[s] < COUNT_SAT)
                    weight[s]++;
                if (sym_total != COUNT_SAT)
                    sym_total++;
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < NSYM; i++)
                    weight[i] = '0;
                sym_total = '0;
            end
            OP_BUILD:
            begin
                build_table();
                a.total = sym_total;
                pending_answers.push_back(a);
            end
            OP_QUERY:
            begin
                a.kind = KIND_QUERY;
                a.total = sym_total;
                a.too_long = len_tab[s] > MAXLEN;
                a.len = a.too_long ? LEN_W'(MAXLEN) : LEN_W'(len_tab[s]);
                a.code = code_tab[s];
                pending_answers.push_back(a);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Send one transaction; called at a falling edge, returns at a falling edge
    task automatic send_cmd(op_t op, logic [SYMBOL_W-1:0] s);
        int gap;
        if (gaps_on && burst_left <= 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        req_if.valid  <= 1'b1;
        req_if.opcode <= op;
        req_if.symbol <= s;
        do
            @(posedge clk);
        while (!req_if.ready);
        apply_cmd(op, s);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic idle_request();
        req_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Receiver stall pattern, overridden by the long hold-off
    always @(negedge clk)
        res_if.ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("tb: unexpected result kind=%0d total=%0d",
                             res_if.kind, res_if.total_count);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (res_if.kind !== want.kind || res_if.total_count !== want.total ||
                    res_if.code_length !== want.len || res_if.code_bits !== want.code ||
                    res_if.too_long !== want.too_long)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("tb: mismatch exp kind=%0d tot=%0d len=%0d code=%h long=%0d %s",
                                 want.kind, want.total, want.len, want.code, want.too_long,
                                 $sformatf("got kind=%0d tot=%0d len=%0d code=%h long=%0d",
                                           res_if.kind, res_if.total_count,
                                           res_if.code_length, res_if.code_bits,
                                           res_if.too_long));
                end
            end
        end
    end

    // Wait until every expected result has come back
    task automatic drain();
        idle_request();
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // Empty histogram, both ends of the symbol range, clear keeping the table
    task automatic test_directed();
        send_cmd(OP_BUILD, 8'd0);
        send_cmd(OP_QUERY, 8'd0);
        send_cmd(OP_QUERY, 8'd255);
        send_cmd(OP_QUERY, 8'd128);
        repeat (3) send_cmd(OP_COUNT, 8'd0);
        repeat (5) send_cmd(OP_COUNT, 8'd255);
        send_cmd(OP_COUNT, 8'd7);
        send_cmd(OP_CLEAR, 8'd0);
        send_cmd(OP_COUNT, 8'd255);
        send_cmd(OP_COUNT, 8'd170);
        send_cmd(OP_COUNT, 8'd85);
        send_cmd(OP_COUNT, 8'd85);
        send_cmd(OP_BUILD, 8'd255);
        send_cmd(OP_QUERY, 8'd0);
        send_cmd(OP_QUERY, 8'd255);
        send_cmd(OP_QUERY, 8'd85);
        send_cmd(OP_QUERY, 8'd170);
        send_cmd(OP_CLEAR, 8'd255);
        send_cmd(OP_QUERY, 8'd85);
        drain();
    endtask

    function automatic logic [SYMBOL_W-1:0] pick_symbol(int shape);
        case (shape)
            0:       return SYMBOL_W'($urandom_range(0, 255));
            1:       return SYMBOL_W'($urandom_range(120, 135));
            default: return SYMBOL_W'($urandom_range(0, 255) >> $urandom_range(0, 7));
        endcase
    endfunction

    // Random histograms, each followed by a build and mixed queries and counts
    task automatic test_random_tables();
        int shape;
        for (int round = 0; round < 3; round++)
        begin
            shape = round;
            gaps_on = (round != 1);
            stall_pct = (round == 2) ? 0 : $urandom_range(10, 60);
            if ($urandom_range(0, 1))
                send_cmd(OP_CLEAR, SYMBOL_W'($urandom));
            repeat ($urandom_range(250, 350))
                send_cmd(OP_COUNT, pick_symbol(shape));
            send_cmd(OP_BUILD, SYMBOL_W'($urandom));
            repeat (220)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_cmd(OP_COUNT, pick_symbol(shape));
                else
                    send_cmd(OP_QUERY, SYMBOL_W'($urandom));
            end
            drain();
        end
    endtask

    // Hold the receiver off while queries and counts keep coming
    task automatic test_backpressure();
        gaps_on = 1'b0;
        stall_pct = 20;
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            repeat (60)
                send_cmd($urandom_range(0, 1) ? OP_QUERY : OP_COUNT, SYMBOL_W'($urandom));
        join
        drain();
    endtask

    initial
    begin
        n_errors = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        hold_off = 1'b0;
        stall_pct = 30;
        sym_total = '0;
        for (int i = 0; i < NNODE; i++)
        begin
            weight[i] = '0;
            parent[i] = NONE;
        end
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.opcode = OP_COUNT;
        req_if.symbol = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_tables();
        test_backpressure();
        if (n_errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
